// ===== hdl/pwmm_pkg.sv =====
// Shared types and constants for the PWM input duty and frequency meter.
// Used by pwmm_div and by pwm_input_duty_frequency_meter_core.
package pwmm_pkg;

    localparam int CNT_W   = 16;          // capture counter width
    localparam int OVF_W   = 16;          // overflow count width
    localparam int TICK_W  = 33;          // measured tick counts
    localparam int FS_W    = 27;          // sampling frequency and frequency result
    localparam int DUTY_W  = 7;           // duty in percent
    localparam int LOST_W  = 16;          // overcapture counters
    localparam int NUM_W   = TICK_W + 6;  // pulse times 100 fits in 39 bits
    localparam int STEP_W  = $clog2(FS_W + 1);
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = FS_W;

    localparam logic [FS_W-1:0]   FS_RESET  = FS_W'(8000000);
    localparam logic [DUTY_W-1:0] DUTY_MAX  = DUTY_W'(100);
    localparam logic [STEP_W-1:0] DUTY_STEPS = STEP_W'(DUTY_W);
    localparam logic [STEP_W-1:0] FREQ_STEPS = STEP_W'(FS_W);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLING_FREQ = 3'd0,
        CFG_WRAP_EN       = 3'd1,
        CFG_FALL_EN       = 3'd2,
        CFG_RISE_EN       = 3'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DUTY,
        S_FREQ,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic             counter_wrapped;
        logic             falling_valid;
        logic [CNT_W-1:0] falling_count;
        logic             rising_valid;
        logic [CNT_W-1:0] rising_count;
        logic             falling_overcapture;
        logic             rising_overcapture;
    } t_in_item;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_percent;
        logic [FS_W-1:0]   frequency_hz;
        logic [TICK_W-1:0] period_ticks;
        logic [TICK_W-1:0] pulse_ticks;
        logic              measurement_done;
        logic [LOST_W-1:0] falling_lost_count;
        logic [LOST_W-1:0] rising_lost_count;
    } t_out_item;

    // Request to the serial divider. The remainder starts at rem_init and the
    // dividend bits are shifted in MSB first, one per step.
    typedef struct packed {
        logic              start;
        logic [TICK_W-1:0] divisor;
        logic [TICK_W-1:0] rem_init;
        logic [FS_W-1:0]   dividend;
        logic [STEP_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic            done;
        logic [FS_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ===== hdl/pwmm_div.sv =====
// Bit-serial restoring divider, one quotient bit per clock.
// Depends on pwmm_pkg for the request and response types.
module pwmm_div
    import pwmm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [TICK_W-1:0] r_rem, n_rem;
    logic [TICK_W-1:0] r_div;
    logic [FS_W-1:0]   r_dvd;
    logic [FS_W-1:0]   r_quo;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [TICK_W+1:0] s_diff;
    logic              s_qbit;

    // The remainder stays below the divisor, so twice it plus one bit fits
    // in one extra bit; the top bit of the difference is the borrow.
    always_comb begin
        s_diff = {1'b0, r_rem, r_dvd[FS_W-1]} - {2'b00, r_div};
        s_qbit = !s_diff[TICK_W+1];
        n_rem  = s_qbit ? s_diff[TICK_W-1:0] : {r_rem[TICK_W-2:0], r_dvd[FS_W-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= i_req.steps;
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= (r_cnt != STEP_W'(1));
            r_done <= (r_cnt == STEP_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.rem_init;
            r_div <= i_req.divisor;
            r_dvd <= i_req.dividend;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[FS_W-2:0], 1'b0};
            r_quo <= {r_quo[FS_W-2:0], s_qbit};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ===== hdl/pwm_input_duty_frequency_meter_core.sv =====
// PWM input meter: pulse width, period, duty in percent and frequency in hertz.
// A request without a rising capture goes from idle to emit; a rising capture goes
// through prep and, unless the pulse exceeds the period, the duty and frequency states
// that run the bit-serial divider (7 steps for duty, 27 for frequency). New requests
// are taken only once emit has moved the result into a free output register.
// Reset is synchronous and active low; it restores the default configuration.
module pwm_input_duty_frequency_meter_core
    import pwmm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input event requests
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    // result requests
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers.
    logic [FS_W-1:0]   r_fs;
    logic              r_wrap_en;
    logic              r_fall_en;
    logic              r_rise_en;

    // Measurement state.
    logic [OVF_W-1:0]  r_fall_ovf, n_fall_ovf;
    logic [OVF_W-1:0]  r_rise_ovf, n_rise_ovf;
    logic [TICK_W-1:0] r_pulse;
    logic [TICK_W-1:0] r_period;
    logic [DUTY_W-1:0] r_duty;
    logic [FS_W-1:0]   r_freq;
    logic [LOST_W-1:0] r_fall_lost;
    logic [LOST_W-1:0] r_rise_lost;
    logic              r_done;

    // Control and output register.
    t_state            r_state, n_state;
    logic              r_out_valid;
    t_out_item         r_out;

    logic              s_in_acc;
    logic              s_fall_hit;
    logic              s_rise_hit;
    logic              s_wrap_hit;
    logic              s_pulse_ok;
    logic              s_out_load;
    logic [TICK_W-1:0] s_fall_ticks;
    logic [TICK_W-1:0] s_rise_ticks;
    logic [NUM_W-1:0]  s_num;
    t_div_req          s_div_req;
    t_div_rsp          s_div_rsp;

    // Configuration writes are always taken: users must send them with the block idle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fs      <= FS_RESET;
            r_wrap_en <= 1'b1;
            r_fall_en <= 1'b1;
            r_rise_en <= 1'b1;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SAMPLING_FREQ: r_fs      <= i_cfg_data[FS_W-1:0];
                CFG_WRAP_EN:       r_wrap_en <= i_cfg_data[0];
                CFG_FALL_EN:       r_fall_en <= i_cfg_data[0];
                CFG_RISE_EN:       r_rise_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Event decode for the item on the input. A capture always holds its
    // edge's overflow count still, so the tick counts use the stored counts.
    always_comb begin
        s_in_acc   = i_in_valid && o_in_ready;
        s_wrap_hit = i_in_data.counter_wrapped && r_wrap_en;
        s_fall_hit = i_in_data.falling_valid && r_fall_en;
        s_rise_hit = i_in_data.rising_valid && r_rise_en;
        s_fall_ticks = {1'b0, r_fall_ovf, i_in_data.falling_count} + TICK_W'(1);
        s_rise_ticks = {1'b0, r_rise_ovf, i_in_data.rising_count} + TICK_W'(1);

        if (s_rise_hit) begin
            n_fall_ovf = '0;
        end else if (s_wrap_hit && !i_in_data.falling_valid && r_fall_ovf != '1) begin
            n_fall_ovf = r_fall_ovf + 1'b1;
        end else begin
            n_fall_ovf = r_fall_ovf;
        end

        if (s_rise_hit) begin
            n_rise_ovf = '0;
        end else if (s_wrap_hit && !i_in_data.rising_valid && r_rise_ovf != '1) begin
            n_rise_ovf = r_rise_ovf + 1'b1;
        end else begin
            n_rise_ovf = r_rise_ovf;
        end
    end

    // Pulse times 100 as 64 + 32 + 4 times the pulse.
    always_comb begin
        s_num = {r_pulse, 6'b0} + {1'b0, r_pulse, 5'b0} + {4'b0, r_pulse, 2'b0};
        s_pulse_ok = (r_pulse <= r_period);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_in_acc) begin
                    n_state = s_rise_hit ? S_PREP : S_EMIT;
                end
            end
            S_PREP: begin
                n_state = s_pulse_ok ? S_DUTY : S_EMIT;
            end
            S_DUTY: begin
                if (s_div_rsp.done) begin
                    n_state = S_FREQ;
                end
            end
            S_FREQ: begin
                if (s_div_rsp.done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs. The duty quotient is known to stay below 128, so the
    // remainder starts with the numerator shifted down by seven bits and
    // only the low seven numerator bits are shifted through the divider.
    always_comb begin
        o_in_ready = 1'b0;
        s_out_load = 1'b0;
        s_div_req  = '0;
        s_div_req.divisor = r_period;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
            end
            S_PREP: begin
                s_div_req.start    = s_pulse_ok;
                s_div_req.rem_init = TICK_W'(s_num[NUM_W-1:DUTY_W]);
                s_div_req.dividend = {s_num[DUTY_W-1:0], (FS_W-DUTY_W)'(0)};
                s_div_req.steps    = DUTY_STEPS;
            end
            S_DUTY: begin
                s_div_req.start    = s_div_rsp.done;
                s_div_req.rem_init = '0;
                s_div_req.dividend = r_fs;
                s_div_req.steps    = FREQ_STEPS;
            end
            S_FREQ: ;
            S_EMIT: begin
                s_out_load = !r_out_valid || i_out_ready;
            end
            default: ;
        endcase
    end

    pwmm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (s_div_req),
        .o_rsp   (s_div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Measurement registers. Input updates happen at the accept edge; duty and
    // frequency land later, before emit: divider results, or zero if pulse > period.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fall_ovf  <= '0;
            r_rise_ovf  <= '0;
            r_pulse     <= '0;
            r_period    <= '0;
            r_duty      <= '0;
            r_freq      <= '0;
            r_fall_lost <= '0;
            r_rise_lost <= '0;
            r_done      <= 1'b0;
        end else begin
            if (s_in_acc) begin
                r_fall_ovf <= n_fall_ovf;
                r_rise_ovf <= n_rise_ovf;
                r_done     <= s_rise_hit;
                if (s_fall_hit) begin
                    r_pulse <= s_fall_ticks;
                end
                if (s_rise_hit) begin
                    r_period <= s_rise_ticks;
                end
                if (i_in_data.falling_overcapture && r_fall_en) begin
                    r_fall_lost <= r_fall_lost + 1'b1;
                end
                if (i_in_data.rising_overcapture && r_rise_en) begin
                    r_rise_lost <= r_rise_lost + 1'b1;
                end
            end
            if (r_state == S_PREP && !s_pulse_ok) begin
                r_duty <= '0;
                r_freq <= '0;
            end
            if (r_state == S_DUTY && s_div_rsp.done) begin
                r_duty <= s_div_rsp.quotient[DUTY_W-1:0];
            end
            if (r_state == S_FREQ && s_div_rsp.done) begin
                r_freq <= s_div_rsp.quotient;
            end
        end
    end

    // Output register: frees the engine while a result waits downstream.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_out_load) begin
            r_out.duty_percent       <= r_duty;
            r_out.frequency_hz       <= r_freq;
            r_out.period_ticks       <= r_period;
            r_out.pulse_ticks        <= r_pulse;
            r_out.measurement_done   <= r_done;
            r_out.falling_lost_count <= r_fall_lost;
            r_out.rising_lost_count  <= r_rise_lost;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // The duty can never exceed one hundred percent.
    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_duty <= DUTY_MAX)
        else $error("duty above 100 percent");

    // The divider only finishes while the sequencer waits for it.
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_div_rsp.done |-> (r_state == S_DUTY || r_state == S_FREQ))
        else $error("divider finished outside a division state");

    // An accepted item blocks further input until it has been emitted.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_in_acc |=> !o_in_ready)
        else $error("input accepted while an item is in flight");
`endif

endmodule

// ===== verif/pwm_input_duty_frequency_meter_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the PWM input duty and frequency meter core.
// Depends on pwmm_pkg and pwm_input_duty_frequency_meter_core from the hdl folder.

import pwmm_pkg::*;

// Keeps a cycle-free copy of the meter state, predicts one reading per event
// request and compares the readings that leave the block in order.
class meter_tracker;

    logic [FS_W-1:0]   fs_hz;
    logic              wrap_en;
    logic              fall_en;
    logic              rise_en;
    logic [OVF_W-1:0]  fall_ovf;
    logic [OVF_W-1:0]  rise_ovf;
    logic [TICK_W-1:0] pulse;
    logic [TICK_W-1:0] period;
    logic [DUTY_W-1:0] duty;
    logic [FS_W-1:0]   freq_hz;
    logic [LOST_W-1:0] fall_lost;
    logic [LOST_W-1:0] rise_lost;
    t_out_item         pending_readings[$];
    int                fail_count;

    function new();
        fs_hz      = FS_RESET;
        wrap_en    = 1'b1;
        fall_en    = 1'b1;
        rise_en    = 1'b1;
        fall_ovf   = '0;
        rise_ovf   = '0;
        pulse      = '0;
        period     = '0;
        duty       = '0;
        freq_hz    = '0;
        fall_lost  = '0;
        rise_lost  = '0;
        fail_count = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_SAMPLING_FREQ: fs_hz = data;
            CFG_WRAP_EN:       wrap_en = data[0];
            CFG_FALL_EN:       fall_en = data[0];
            CFG_RISE_EN:       rise_en = data[0];
            default: ;
        endcase
    endfunction

    function logic [OVF_W-1:0] bump_saturating(logic [OVF_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    // Capture plus one, extended by the overflows seen since the last period.
    function logic [TICK_W-1:0] ticks_from(logic [CNT_W-1:0] cap, logic [OVF_W-1:0] ovf);
        bit [63:0] t;
        t = 64'(cap) + 64'd1 + (64'(ovf) << CNT_W);
        return (t > 64'({TICK_W{1'b1}})) ? {TICK_W{1'b1}} : t[TICK_W-1:0];
    endfunction

    function void note_request(t_in_item it);
        t_out_item r;
        bit [63:0] scaled;
        r.measurement_done = 1'b0;
        if (it.counter_wrapped && wrap_en) begin
            if (!it.falling_valid) fall_ovf = bump_saturating(fall_ovf);
            if (!it.rising_valid) rise_ovf = bump_saturating(rise_ovf);
        end
        if (it.falling_valid && fall_en) pulse = ticks_from(it.falling_count, fall_ovf);
        if (it.rising_valid && rise_en) begin
            period = ticks_from(it.rising_count, rise_ovf);
            if (period != '0 && pulse <= period) begin
                scaled  = 64'(pulse) * 64'd100;
                duty    = DUTY_W'(scaled / 64'(period));
                freq_hz = FS_W'(64'(fs_hz) / 64'(period));
            end else begin
                duty    = '0;
                freq_hz = '0;
            end
            fall_ovf = '0;
            rise_ovf = '0;
            r.measurement_done = 1'b1;
        end
        if (it.falling_overcapture && fall_en) fall_lost = fall_lost + 1'b1;
        if (it.rising_overcapture && rise_en) rise_lost = rise_lost + 1'b1;
        r.duty_percent       = duty;
        r.frequency_hz       = freq_hz;
        r.period_ticks       = period;
        r.pulse_ticks        = pulse;
        r.falling_lost_count = fall_lost;
        r.rising_lost_count  = rise_lost;
        pending_readings.push_back(r);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    function void check_result(t_out_item got);
        t_out_item want;
        if (pending_readings.size() == 0) begin
            $error("reading returned with no event request outstanding");
            fail_count++;
            return;
        end
        want = pending_readings.pop_front();
        compare_field("duty_percent", 64'(want.duty_percent), 64'(got.duty_percent));
        compare_field("frequency_hz", 64'(want.frequency_hz), 64'(got.frequency_hz));
        compare_field("period_ticks", 64'(want.period_ticks), 64'(got.period_ticks));
        compare_field("pulse_ticks", 64'(want.pulse_ticks), 64'(got.pulse_ticks));
        compare_field("measurement_done", 64'(want.measurement_done),
                      64'(got.measurement_done));
        compare_field("falling_lost_count", 64'(want.falling_lost_count),
                      64'(got.falling_lost_count));
        compare_field("rising_lost_count", 64'(want.rising_lost_count),
                      64'(got.rising_lost_count));
    endfunction
endclass

module pwm_input_duty_frequency_meter_core_tb;
    import pwmm_pkg::*;

    // Indexes 4 to 7 decode to no register; writes there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;
    localparam logic [FS_W-1:0]      FS_RANGE_MAX     = FS_W'(100000000);
    // A long run of wraps that builds up large overflow counts.
    localparam int                   LONG_WRAP_EVENTS = 40;
    localparam int                   CYCLE_LIMIT      = 2000000;
    localparam int                   SETTLE_CYCLES    = 60;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_data;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    pwm_input_duty_frequency_meter_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    meter_tracker tracker = new();
    bit           idle_on;
    int unsigned  cycle_count;
    int           sent_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // All handshakes are observed at the rising edge. The testbench drives its
    // side at the falling edge, so every value seen here is settled. Readings
    // are checked before the request of the same edge is noted; a request can
    // never produce its reading on the edge that accepts it.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) tracker.check_result(o_out_data);
            if (i_cfg_valid && o_cfg_ready) tracker.write_register(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready) tracker.note_request(i_in_data);
        end
    end

    // The result side stalls in short random bursts while idling is on, and
    // otherwise takes every reading at once.
    initial begin
        i_out_ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                i_out_ready = 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
        end
    end

    function automatic t_in_item make_event(bit wrap, bit fv, logic [CNT_W-1:0] fc,
                                            bit rv, logic [CNT_W-1:0] rc, bit fo, bit ro);
        t_in_item it;
        it.counter_wrapped     = wrap;
        it.falling_valid       = fv;
        it.falling_count       = fc;
        it.rising_valid        = rv;
        it.rising_count        = rc;
        it.falling_overcapture = fo;
        it.rising_overcapture  = ro;
        return it;
    endfunction

    function automatic logic [CNT_W-1:0] any_count();
        return CNT_W'($urandom_range(0, 16'hFFFF));
    endfunction

    function automatic bit rare_flag();
        return ($urandom_range(0, 7) == 0);
    endfunction

    // Presents one event request and holds it until the block takes it. Valid
    // stays high afterwards, so back-to-back requests run without a gap; while
    // idling is on, a random gap may drop it first.
    task automatic send_event(input t_in_item it);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_in_data  = it;
        i_in_valid = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
        sent_count++;
    endtask

    task automatic program_register(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
        i_cfg_index = idx;
        i_cfg_data  = data;
        i_cfg_valid = 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Stops sending and waits until every predicted reading has been returned.
    // Every request yields a reading, so the block is idle once this returns.
    task automatic settle_results();
        i_in_valid = 1'b0;
        while (tracker.pending_readings.size() != 0) @(negedge i_clk);
    endtask

    task automatic program_all(input logic [FS_W-1:0] fs, input bit wrap, input bit fall,
                               input bit rise);
        settle_results();
        program_register(CFG_SAMPLING_FREQ, fs);
        program_register(CFG_WRAP_EN, CFG_DATA_W'(wrap));
        program_register(CFG_FALL_EN, CFG_DATA_W'(fall));
        program_register(CFG_RISE_EN, CFG_DATA_W'(rise));
    endtask

    // One PWM period as a timer would report it: some wraps, the falling
    // capture, more wraps, then the rising capture that closes the period.
    // Now and then a capture coincides with a wrap or both edges land together.
    task automatic send_measurement();
        int lead_wraps;
        int mid_wraps;
        lead_wraps = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 20) : $urandom_range(0, 2);
        mid_wraps  = $urandom_range(0, 2);
        repeat (lead_wraps)
            send_event(make_event(1'b1, 1'b0, any_count(), 1'b0, any_count(),
                                  rare_flag(), rare_flag()));
        send_event(make_event($urandom_range(0, 3) == 0, 1'b1, any_count(), 1'b0, any_count(),
                              rare_flag(), rare_flag()));
        repeat (mid_wraps)
            send_event(make_event(1'b1, 1'b0, any_count(), 1'b0, any_count(),
                                  rare_flag(), rare_flag()));
        send_event(make_event($urandom_range(0, 3) == 0, $urandom_range(0, 9) == 0, any_count(),
                              1'b1, any_count(), rare_flag(), rare_flag()));
    endtask

    task automatic run_random(input int n_items);
        int first;
        first = sent_count;
        while (sent_count - first < n_items) begin
            // Occasionally the sender holds off until the block has drained.
            if ($urandom_range(0, 59) == 0) settle_results();
            if ($urandom_range(0, 9) < 7) begin
                send_measurement();
            end else begin
                send_event(make_event(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                      any_count(), 1'($urandom_range(0, 1)), any_count(),
                                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
            end
        end
    endtask

    initial begin
        bit fall_pick;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        idle_on     = 1'b1;
        cycle_count = 0;
        sent_count  = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Default configuration: empty event, shortest pulse and period, a wrap
        // that coincides with the falling capture, longest single-wrap values,
        // a pulse longer than the period, a wrap that coincides with the rising
        // capture, every field set at once, and overcaptures alone.
        send_event(make_event(1'b0, 1'b0, 16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0));
        send_event(make_event(1'b0, 1'b1, 16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0));
        send_event(make_event(1'b0, 1'b0, 16'h0000, 1'b1, 16'h0000, 1'b0, 1'b0));
        send_event(make_event(1'b1, 1'b1, 16'hFFFF, 1'b0, 16'h0000, 1'b0, 1'b0));
        send_event(make_event(1'b0, 1'b0, 16'h0000, 1'b1, 16'hFFFF, 1'b0, 1'b0));
        send_event(make_event(1'b0, 1'b1, 16'hFFFF, 1'b0, 16'h0000, 1'b0, 1'b0));
        send_event(make_event(1'b0, 1'b0, 16'h0000, 1'b1, 16'h0000, 1'b0, 1'b0));
        send_event(make_event(1'b1, 1'b0, 16'h0000, 1'b1, 16'h1234, 1'b0, 1'b0));
        send_event(make_event(1'b1, 1'b1, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1, 1'b1));
        send_event(make_event(1'b0, 1'b0, 16'h0000, 1'b0, 16'h0000, 1'b1, 1'b1));

        // A zero sampling rate gives zero frequency. Writes to the unused
        // indexes must leave it that way.
        settle_results();
        program_register(CFG_SAMPLING_FREQ, '0);
        program_register(CFG_IDX_SPARE_LO, '1);
        program_register(CFG_IDX_SPARE_HI, '1);
        send_event(make_event(1'b0, 1'b1, 16'h00FF, 1'b0, 16'h0000, 1'b0, 1'b0));
        send_event(make_event(1'b0, 1'b0, 16'h0000, 1'b1, 16'h0FFF, 1'b0, 1'b0));

        // Widest sampling rate. Wraps are masked through a write whose low bit
        // is clear, and falling events are ignored outright.
        settle_results();
        program_register(CFG_SAMPLING_FREQ, '1);
        program_register(CFG_WRAP_EN, CFG_DATA_W'(2));
        program_register(CFG_FALL_EN, '0);
        send_event(make_event(1'b1, 1'b0, 16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0));
        send_event(make_event(1'b1, 1'b1, 16'h7777, 1'b0, 16'h0000, 1'b1, 1'b0));
        send_event(make_event(1'b0, 1'b0, 16'h0000, 1'b1, 16'h0000, 1'b0, 1'b0));

        // With both edges disabled a wrap still skips the edge whose valid bit
        // is set, whatever that edge's enable says.
        settle_results();
        program_register(CFG_WRAP_EN, CFG_DATA_W'(1));
        program_register(CFG_RISE_EN, '0);
        send_event(make_event(1'b1, 1'b1, 16'h0001, 1'b0, 16'h0000, 1'b0, 1'b0));
        send_event(make_event(1'b0, 1'b0, 16'h0000, 1'b1, 16'hAAAA, 1'b0, 1'b1));
        send_event(make_event(1'b1, 1'b0, 16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0));
        settle_results();
        program_register(CFG_FALL_EN, CFG_DATA_W'(1));
        program_register(CFG_RISE_EN, CFG_DATA_W'(1));
        send_event(make_event(1'b0, 1'b1, 16'h8000, 1'b0, 16'h0000, 1'b0, 1'b0));
        send_event(make_event(1'b0, 1'b0, 16'h0000, 1'b1, 16'h8000, 1'b0, 1'b0));

        // Random traffic under several settings, the range ends among them.
        program_all(FS_W'($urandom_range(1, 100000000)), 1'b1, 1'b1, 1'b1);
        run_random(250);
        program_all(FS_RANGE_MAX, 1'b0, 1'b1, 1'b1);
        run_random(150);
        fall_pick = 1'($urandom_range(0, 1));
        program_all(FS_W'(1), 1'b1, fall_pick, ~fall_pick);
        run_random(150);

        // From here on neither side idles. A long run of wraps with overcaptures
        // builds up both overflow counts while the lost counters climb; a long
        // pulse and period then follow.
        idle_on = 1'b0;
        program_all(FS_RESET, 1'b1, 1'b1, 1'b1);
        send_event(make_event(1'b0, 1'b0, 16'h0000, 1'b1, 16'h0000, 1'b0, 1'b0));
        repeat (LONG_WRAP_EVENTS)
            send_event(make_event(1'b1, 1'b0, 16'hFFFF, 1'b0, 16'hFFFF, 1'b1, 1'b1));
        send_event(make_event(1'b0, 1'b1, 16'hFFFF, 1'b0, 16'h0000, 1'b0, 1'b0));
        send_event(make_event(1'b0, 1'b0, 16'h0000, 1'b1, 16'hFFFF, 1'b0, 1'b0));

        program_all(FS_RESET, 1'b1, 1'b1, 1'b1);
        run_random(200);

        settle_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (tracker.pending_readings.size() != 0) begin
            $error("%0d readings never returned", tracker.pending_readings.size());
            tracker.fail_count++;
        end
        if (tracker.fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
